// ===== sv/refcounted_page_mapping_table_unit_assert.svh =====
// Assertion macros for the page mapping table, clocked on clock, disabled in reset
`ifndef REFCOUNTED_PAGE_MAPPING_TABLE_UNIT_ASSERT_SVH
`define REFCOUNTED_PAGE_MAPPING_TABLE_UNIT_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define RPMT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define RPMT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rpmt_pkg.sv =====
// Shared types and constants of the page mapping table
package rpmt_pkg;

   localparam int SLOT_COUNT_DEFAULT = 64;
   localparam int MAX_PAGES_DEFAULT  = 16;

   localparam int PAGE_W    = 20;
   localparam int OFFSET_W  = 12;
   localparam int REFS_W    = 16;
   localparam int SIZE_W    = 16;
   localparam int ADDR_W    = 32;
   localparam int SUM_W     = 17;

   localparam logic [OFFSET_W-1:0] OFFSET_MASK = 12'hFFF;
   localparam logic [REFS_W-1:0]   REFS_MAX    = 16'hFFFF;
   localparam logic [PAGE_W-1:0]   BASE_VPAGE_RESET = 20'd917504;

   // Request operation codes
   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_MAP   = 2'd0;
   localparam logic [1:0] KIND_UNMAP = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [PAGE_W-1:0] virtual_page;
      logic [PAGE_W-1:0] physical_page;
      logic [ADDR_W-1:0] return_address;
      logic              slot_recorded;
      logic              last;
   } rsp_type;

   // Compare flags for one slot against the request key
   typedef struct packed {
      logic hit;
      logic free;
   } match_type;

endpackage

// ===== sv/rpmt_slot_mem.sv =====
// Slot memory with one read and one write port and per-slot valid bits
module rpmt_slot_mem #(
   parameter int SLOT_COUNT = rpmt_pkg::SLOT_COUNT_DEFAULT,
   parameter int SLOT_W     = 61
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear_all,
   input  logic                          rd_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
   output logic [SLOT_W-1:0]             rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
   input  logic [SLOT_W-1:0]             wr_data
);
   import rpmt_pkg::*;

   logic [SLOT_W-1:0]     mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [SLOT_COUNT-1:0] valid_in;
   logic [SLOT_W-1:0]     data_ff;
   logic                  vld_ff;

   // Clear all valid bits on init, set one on write
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a slot not written since reset or the last init reads as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         vld_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = vld_ff ? data_ff : '0;

endmodule

// ===== sv/rpmt_match_unit.sv =====
// Shared slot compare unit used on every step of the table scan
module rpmt_match_unit (
   input  logic                         is_map,
   input  logic [rpmt_pkg::PAGE_W-1:0]  key_page,
   input  logic [rpmt_pkg::PAGE_W-1:0]  slot_vpage,
   input  logic [rpmt_pkg::PAGE_W-1:0]  slot_ppage,
   input  logic [rpmt_pkg::REFS_W-1:0]  slot_refs,
   output rpmt_pkg::match_type          result
);
   import rpmt_pkg::*;

   logic refs_zero;

   assign refs_zero = (slot_refs == '0);

   // Map matches on physical page, unmap on virtual page among live slots
   always_comb begin
      result.free = refs_zero;
      if (is_map) begin
         result.hit = (slot_ppage == key_page);
      end else begin
         result.hit = (slot_vpage == key_page) && !refs_zero;
      end
   end

endmodule

// ===== sv/refcounted_page_mapping_table_unit.sv =====
// Top level of the reference-counted page mapping table.
// Map and unmap scan every slot, reading one slot per cycle through the registered read
// port of the slot memory, then send N page commands and the done result, N being the
// number of page commands; init and unknown operations go straight to the done result.
// One request is taken at a time: a new request stalls until the done result is sent.
// Synchronous active-high reset empties the table and loads base and pointer with 917504.
`include "refcounted_page_mapping_table_unit_assert.svh"

module refcounted_page_mapping_table_unit #(
   parameter int SLOT_COUNT = rpmt_pkg::SLOT_COUNT_DEFAULT,
   parameter int MAX_PAGES  = rpmt_pkg::MAX_PAGES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [rpmt_pkg::PAGE_W-1:0] csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rpmt_pkg::req_type           req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rpmt_pkg::rsp_type           rsp_payload
);
   import rpmt_pkg::*;

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int SLOT_W = PAGE_W + PAGE_W + CNT_W + REFS_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [PAGE_W-1:0]   key_ff, key_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [CNT_W-1:0]    pages_ff, pages_in;
   logic [PAGE_W-1:0]   base_ff, base_in;
   logic [PAGE_W-1:0]   next_vp_ff, next_vp_in;
   logic [IDX_W:0]      scan_ff, scan_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [PAGE_W-1:0]   hit_vp_ff, hit_vp_in;
   logic [PAGE_W-1:0]   hit_pp_ff, hit_pp_in;
   logic [CNT_W-1:0]    hit_cnt_ff, hit_cnt_in;
   logic [REFS_W-1:0]   hit_refs_ff, hit_refs_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [1:0]          emit_kind_ff, emit_kind_in;
   logic [CNT_W-1:0]    emit_k_ff, emit_k_in;
   logic [CNT_W-1:0]    emit_end_ff, emit_end_in;
   logic [PAGE_W-1:0]   emit_vbase_ff, emit_vbase_in;
   logic [PAGE_W-1:0]   emit_pbase_ff, emit_pbase_in;
   logic [ADDR_W-1:0]   ret_ff, ret_in;
   logic                rec_ff, rec_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;

   logic                req_accept;
   logic                out_free;
   logic                clear_all;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [SLOT_W-1:0]   wr_data;
   logic [PAGE_W-1:0]   rd_vp;
   logic [PAGE_W-1:0]   rd_pp;
   logic [CNT_W-1:0]    rd_cnt;
   logic [REFS_W-1:0]   rd_refs;
   match_type           mres;
   logic [SUM_W-1:0]    page_sum;
   logic [4:0]          raw_pages;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Page count of a map request, before saturation
   assign page_sum  = SUM_W'(req_payload.address[OFFSET_W-1:0])
                    + SUM_W'(req_payload.size) + SUM_W'(OFFSET_MASK);
   assign raw_pages = page_sum[SUM_W-1:OFFSET_W];

   // Unpack the slot record read back from memory
   assign rd_vp   = rd_data[SLOT_W-1 -: PAGE_W];
   assign rd_pp   = rd_data[SLOT_W-PAGE_W-1 -: PAGE_W];
   assign rd_cnt  = rd_data[REFS_W +: CNT_W];
   assign rd_refs = rd_data[REFS_W-1:0];

   assign rd_en = (state_ff == ST_SCAN) && (scan_ff < (IDX_W+1)'(SLOT_COUNT));
   assign clear_all = req_accept && (req_payload.operation == OP_INIT);

   rpmt_slot_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_W     (SLOT_W)
   ) u_slot_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .rd_en     (rd_en),
      .rd_addr   (scan_ff[IDX_W-1:0]),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   rpmt_match_unit u_match (
      .is_map     (op_ff == OP_MAP),
      .key_page   (key_ff),
      .slot_vpage (rd_vp),
      .slot_ppage (rd_pp),
      .slot_refs  (rd_refs),
      .result     (mres)
   );

   // Sequencer: accept, scan, decide, send commands, send done
   always_comb begin
      logic [CNT_W-1:0]  new_cnt;
      logic [REFS_W-1:0] new_refs;
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      offset_in     = offset_ff;
      pages_in      = pages_ff;
      base_in       = base_ff;
      next_vp_in    = next_vp_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_vp_in     = hit_vp_ff;
      hit_pp_in     = hit_pp_ff;
      hit_cnt_in    = hit_cnt_ff;
      hit_refs_in   = hit_refs_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      emit_kind_in  = emit_kind_ff;
      emit_k_in     = emit_k_ff;
      emit_end_in   = emit_end_ff;
      emit_vbase_in = emit_vbase_ff;
      emit_pbase_in = emit_pbase_ff;
      ret_in        = ret_ff;
      rec_in        = rec_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = '0;
      new_cnt       = '0;
      new_refs      = '0;

      // Hold the base register for the next init
      if (csr_write_enable) begin
         base_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_payload.operation;
               key_in    = req_payload.address[ADDR_W-1:OFFSET_W];
               offset_in = req_payload.address[OFFSET_W-1:0];
               if (32'(raw_pages) > 32'(MAX_PAGES)) begin
                  pages_in = CNT_W'(MAX_PAGES);
               end else begin
                  pages_in = CNT_W'(raw_pages);
               end
               scan_in = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               ret_in  = '0;
               rec_in  = 1'b0;
               if (req_payload.operation == OP_MAP
                   || req_payload.operation == OP_UNMAP) begin
                  state_in = ST_SCAN;
               end else begin
                  if (req_payload.operation == OP_INIT) begin
                     next_vp_in = base_ff;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle, check the slot read the cycle before
            if (rd_en) begin
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = scan_ff[IDX_W-1:0];
            end
            if (rd_pend_ff) begin
               if (mres.hit && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_vp_in   = rd_vp;
                  hit_pp_in   = rd_pp;
                  hit_cnt_in  = rd_cnt;
                  hit_refs_in = rd_refs;
               end
               if (mres.free && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (op_ff == OP_MAP) begin
               emit_kind_in  = KIND_MAP;
               emit_pbase_in = key_ff;
               rec_in        = hit_ff || free_ff;
               if (hit_ff) begin
                  // Reuse the slot, map only pages beyond those already there
                  emit_vbase_in = hit_vp_ff;
                  emit_k_in     = hit_cnt_ff;
                  if (pages_ff > hit_cnt_ff) begin
                     emit_end_in = pages_ff;
                     new_cnt     = pages_ff;
                  end else begin
                     emit_end_in = hit_cnt_ff;
                     new_cnt     = hit_cnt_ff;
                  end
                  if (hit_refs_ff != REFS_MAX) begin
                     new_refs = hit_refs_ff + 1'b1;
                  end else begin
                     new_refs = hit_refs_ff;
                  end
                  wr_en   = 1'b1;
                  wr_addr = hit_idx_ff;
                  wr_data = {hit_vp_ff, key_ff, new_cnt, new_refs};
                  ret_in  = {hit_vp_ff, offset_ff};
               end else begin
                  // Take pages from the bump pointer, record if a slot is free
                  emit_vbase_in = next_vp_ff;
                  emit_k_in     = '0;
                  emit_end_in   = pages_ff;
                  next_vp_in    = next_vp_ff + PAGE_W'(pages_ff);
                  wr_en   = free_ff;
                  wr_addr = free_idx_ff;
                  wr_data = {next_vp_ff, key_ff, pages_ff, REFS_W'(1)};
                  ret_in  = {next_vp_ff, offset_ff};
               end
            end else begin
               emit_kind_in  = KIND_UNMAP;
               emit_vbase_in = key_ff;
               emit_pbase_in = '0;
               emit_k_in     = '0;
               emit_end_in   = '0;
               if (hit_ff) begin
                  // Drop one reference, release all pages at zero
                  new_refs = hit_refs_ff - 1'b1;
                  new_cnt  = hit_cnt_ff;
                  if (new_refs == '0) begin
                     emit_end_in = hit_cnt_ff;
                     new_cnt     = '0;
                  end
                  wr_en   = 1'b1;
                  wr_addr = hit_idx_ff;
                  wr_data = {hit_vp_ff, hit_pp_ff, new_cnt, new_refs};
               end
            end
            if (emit_k_in < emit_end_in) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.kind          = emit_kind_ff;
               rsp_payload_in.virtual_page  = emit_vbase_ff + PAGE_W'(emit_k_ff);
               if (emit_kind_ff == KIND_MAP) begin
                  rsp_payload_in.physical_page = emit_pbase_ff + PAGE_W'(emit_k_ff);
               end else begin
                  rsp_payload_in.physical_page = '0;
               end
               rsp_payload_in.return_address = '0;
               rsp_payload_in.slot_recorded  = 1'b0;
               rsp_payload_in.last           = 1'b0;
               emit_k_in = emit_k_ff + 1'b1;
               if (emit_k_in == emit_end_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in.kind           = KIND_DONE;
               rsp_payload_in.virtual_page   = '0;
               rsp_payload_in.physical_page  = '0;
               rsp_payload_in.return_address = ret_ff;
               rsp_payload_in.slot_recorded  = rec_ff;
               rsp_payload_in.last           = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= BASE_VPAGE_RESET;
         next_vp_ff   <= BASE_VPAGE_RESET;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_vp_ff   <= next_vp_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      offset_ff      <= offset_in;
      pages_ff       <= pages_in;
      scan_ff        <= scan_in;
      rd_idx_ff      <= rd_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_vp_ff      <= hit_vp_in;
      hit_pp_ff      <= hit_pp_in;
      hit_cnt_ff     <= hit_cnt_in;
      hit_refs_ff    <= hit_refs_in;
      free_idx_ff    <= free_idx_in;
      emit_kind_ff   <= emit_kind_in;
      emit_k_ff      <= emit_k_in;
      emit_end_ff    <= emit_end_in;
      emit_vbase_ff  <= emit_vbase_in;
      emit_pbase_ff  <= emit_pbase_in;
      ret_ff         <= ret_in;
      rec_ff         <= rec_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   `RPMT_ASSERT_NEXT(a_accept_leaves_idle, req_accept,
      state_ff != ST_IDLE, "accept did not start work")
   `RPMT_ASSERT_NOW(a_emit_in_range, state_ff == ST_EMIT,
      emit_k_ff < emit_end_ff, "page command past end")
   `RPMT_ASSERT_NOW(a_write_only_decide, wr_en,
      state_ff == ST_DECIDE, "slot write outside decide")
   `RPMT_ASSERT_NEXT(a_decide_to_output, state_ff == ST_DECIDE,
      state_ff == ST_EMIT || state_ff == ST_DONE, "decide went astray")

endmodule
